>>> design/tguc_pkg.sv
package tguc_pkg;
   localparam int GRID_SIZE = 8;
   localparam int COL_W = $clog2(GRID_SIZE);
   localparam int IDX_W = $clog2(GRID_SIZE * GRID_SIZE);
   localparam logic signed [11:0] PEAK_INIT = -12'sd1000;
   localparam logic [7:0] SEG1 = 8'd85;
   localparam logic [7:0] SEG2 = 8'd170;
   localparam logic CSR_COLOR_LOW = 1'b0;
   localparam logic CSR_COLOR_SPAN = 1'b1;

   typedef struct packed {
      logic [2:0] band;
      logic       last_band;
      logic       last_row;
   } job_type;

   function automatic logic [15:0] ramp565(input logic [7:0] i);
      logic [7:0] r, g, b;
      logic [9:0] t;
      begin
         r = '0; g = '0; b = '0;
         if (i < SEG1) begin
            t = 10'(i) * 10'd3;
            b = 8'(10'd255 - t);
            g = t[7:0];
         end else if (i < SEG2) begin
            t = 10'(i - SEG1) * 10'd3;
            g = 8'd255;
            r = t[7:0];
         end else begin
            t = 10'(i - SEG2) * 10'd3;
            r = 8'd255;
            g = 8'(10'd255 - t);
         end
         ramp565 = {r[7:3], g[7:2], b[7:3]};
      end
   endfunction
endpackage

>>> design/tguc_front.sv
module tguc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_sample_code,
   output logic                job_valid,
   output tguc_pkg::job_type   job,
   input  logic                job_ready,
   input  logic                back_busy,
   output logic                wr_en,
   output logic [tguc_pkg::COL_W:0] wr_addr,
   output logic signed [11:0]  wr_data,
   output logic                frame_start
);
   import tguc_pkg::*;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0] c;
   logic [IDX_W-COL_W-1:0] r;
   logic acc, emit;

   assign r = idx_ff[IDX_W-1:COL_W];
   assign c = idx_ff[COL_W-1:0];
   assign emit = (c == COL_W'(GRID_SIZE - 1)) && (r != '0);
   // a new sample waits while the back end is busy, and at a row end until the job is taken
   assign req_ready = !back_busy && (!emit || job_ready);
   assign acc = req_valid && req_ready;
   assign job_valid = req_valid && emit && !back_busy;
   assign job.band = 3'(r - 1'b1);
   assign job.last_row = (r == (IDX_W-COL_W)'(GRID_SIZE - 1));
   assign job.last_band = 1'b0;
   assign wr_en = acc;
   assign wr_addr = {r[0], c};
   assign wr_data = req_sample_code;
   assign frame_start = acc && (idx_ff == '0);

   always_comb begin
      idx_in = idx_ff;
      if (acc) begin
         if (idx_ff == IDX_W'(GRID_SIZE * GRID_SIZE - 1)) idx_in = '0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end
endmodule

>>> design/tguc_back.sv
module tguc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  tguc_pkg::job_type   job,
   output logic                job_ready,
   output logic                back_busy,
   input  logic                wr_en,
   input  logic [tguc_pkg::COL_W:0] wr_addr,
   input  logic signed [11:0]  wr_data,
   input  logic                frame_start,
   input  logic signed [11:0]  color_low,
   input  logic [11:0]         color_span,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_pixel_row,
   output logic [2:0]          rsp_cell_column,
   output logic [15:0]         rsp_colour_a,
   output logic [15:0]         rsp_colour_b,
   output logic [15:0]         rsp_colour_c,
   output logic [15:0]         rsp_colour_d,
   output logic                rsp_run_last,
   output logic                rsp_frame_end,
   output logic signed [11:0]  rsp_frame_peak,
   output logic [6:0]          rsp_peak_x,
   output logic [6:0]          rsp_peak_y
);
   import tguc_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_MUL = 3'd2, S_DIV = 3'd3,
      S_OUT = 3'd4;

   // one-entry job queue, decoupled from the front
   logic q_full_ff, q_full_in;
   job_type q_ff;
   logic signed [11:0] mem [2*GRID_SIZE];
   logic [2:0] st_ff, st_in;
   job_type cur_ff;
   logic [1:0] ry_ff;
   logic [COL_W-1:0] gx_ff;
   logic signed [11:0] s00_ff, s01_ff, s10_ff, s11_ff;
   logic signed [21:0] prod_ff;
   logic [12:0] div_rem_ff;
   logic [21:0] div_q_ff;
   logic [4:0] div_cnt_ff;
   logic div_neg_ff;
   logic [1:0] px_ff;
   logic [15:0] col_ff [4];
   logic signed [11:0] pk_ff;
   logic [4:0] pc_ff, pr_ff;
   logic out_v_ff;
   logic col_we_ff;
   logic [1:0] col_px_ff;
   logic out_go;
   logic [COL_W-1:0] gx2;
   logic [COL_W:0] rda_top, rda_bot;
   logic [2:0] wx1, wy1;
   logic signed [17:0] sum;
   logic signed [11:0] tq;
   logic [12:0] spn, rem_sh;
   logic [21:0] amag;
   logic [7:0] pidx;
   logic [4:0] xpos, ypos;
   logic cell_last, band_done;
   logic [2:0] band_sel;

   assign job_ready = !q_full_ff;
   assign back_busy = q_full_ff || (st_ff != S_IDLE);
   assign gx2 = (gx_ff == COL_W'(GRID_SIZE - 1)) ? gx_ff : gx_ff + 1'b1;
   assign band_sel = cur_ff.last_band ? cur_ff.band + 3'd1 : cur_ff.band;
   assign rda_top = {band_sel[0], COL_W'(0)};
   assign rda_bot = cur_ff.last_band ? rda_top : {~band_sel[0], COL_W'(0)};
   assign wx1 = 3'd4 - 3'(px_ff);
   assign wy1 = 3'd4 - 3'(ry_ff);
   assign sum = 18'(s00_ff) * $signed({1'b0, wx1}) * $signed({1'b0, wy1})
              + 18'(s01_ff) * $signed({1'b0, 3'(px_ff)}) * $signed({1'b0, wy1})
              + 18'(s10_ff) * $signed({1'b0, wx1}) * $signed({1'b0, 3'(ry_ff)})
              + 18'(s11_ff) * $signed({1'b0, 3'(px_ff)}) * $signed({1'b0, 3'(ry_ff)});
   // truncate toward zero
   assign tq = 12'((sum + (sum[17] ? 18'sd15 : 18'sd0)) >>> 4);
   assign spn = (color_span == '0) ? 13'd1 : {1'b0, color_span};
   assign amag = prod_ff[21] ? 22'(-prod_ff) : 22'(prod_ff);
   assign rem_sh = {div_rem_ff[11:0], amag[5'd21 - div_cnt_ff]};
   assign xpos = 5'({gx_ff, px_ff});
   assign ypos = 5'({band_sel, ry_ff});
   assign cell_last = (gx_ff == COL_W'(GRID_SIZE - 1));
   assign band_done = cell_last && (ry_ff == 2'd3);
   // last pixel colour lands in the cycle after its final divide step
   assign out_go = !col_we_ff && (!out_v_ff || rsp_ready);
   always_comb begin
      if (div_neg_ff) pidx = '0;
      else if (div_q_ff > 22'd255) pidx = 8'd255;
      else pidx = div_q_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      s00_ff <= mem[rda_top | (COL_W+1)'(gx_ff)];
      s01_ff <= mem[rda_top | (COL_W+1)'(gx2)];
      s10_ff <= mem[rda_bot | (COL_W+1)'(gx_ff)];
      s11_ff <= mem[rda_bot | (COL_W+1)'(gx2)];
   end

   always_comb begin
      q_full_in = q_full_ff;
      if (job_valid && job_ready) q_full_in = 1'b1;
      if (st_ff == S_IDLE && q_full_ff) q_full_in = 1'b0;
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (q_full_ff) st_in = S_RD;
         S_RD: st_in = S_MUL;
         S_MUL: st_in = S_DIV;
         S_DIV: if (div_cnt_ff == 5'd21 && !(out_v_ff && !rsp_ready))
            st_in = (px_ff == 2'd3) ? S_OUT : S_MUL;
         S_OUT: if (out_go) begin
            if (!band_done) st_in = S_RD;
            else if (cur_ff.last_row && !cur_ff.last_band) st_in = S_RD;
            else st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         q_full_ff <= 1'b0;
         out_v_ff <= 1'b0;
         pk_ff <= PEAK_INIT;
         pc_ff <= '0;
         pr_ff <= '0;
      end else begin
         st_ff <= st_in;
         q_full_ff <= q_full_in;
         if (out_v_ff && rsp_ready) out_v_ff <= 1'b0;
         if (frame_start) pk_ff <= PEAK_INIT;
         if (job_valid && job_ready) q_ff <= job;
         case (st_ff)
            S_IDLE: if (q_full_ff) begin
               cur_ff <= q_ff;
               gx_ff <= '0;
               ry_ff <= '0;
            end
            S_RD: px_ff <= '0;
            S_MUL: begin
               prod_ff <= 22'(($signed({tq[11], tq}) - $signed({color_low[11], color_low}))
                         * 22'sd255);
               div_rem_ff <= '0;
               div_q_ff <= '0;
               div_cnt_ff <= '0;
               if (tq > pk_ff) begin
                  pk_ff <= tq;
                  pc_ff <= xpos;
                  pr_ff <= ypos;
               end
            end
            S_DIV: if (div_cnt_ff != 5'd21 || !(out_v_ff && !rsp_ready)) begin
               if (rem_sh >= spn) begin
                  div_rem_ff <= rem_sh - spn;
                  div_q_ff <= {div_q_ff[20:0], 1'b1};
               end else begin
                  div_rem_ff <= rem_sh;
                  div_q_ff <= {div_q_ff[20:0], 1'b0};
               end
               div_neg_ff <= prod_ff[21];
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == 5'd21) begin
                  px_ff <= px_ff + 1'b1;
               end
            end
            S_OUT: if (out_go) begin
               out_v_ff <= 1'b1;
               rsp_pixel_row <= ypos;
               rsp_cell_column <= 3'(gx_ff);
               rsp_colour_a <= col_ff[0];
               rsp_colour_b <= col_ff[1];
               rsp_colour_c <= col_ff[2];
               rsp_colour_d <= col_ff[3];
               rsp_frame_peak <= pk_ff;
               rsp_peak_x <= {pc_ff, 2'b00};
               rsp_peak_y <= {pr_ff, 2'b00};
               rsp_run_last <= band_done && (!cur_ff.last_row || cur_ff.last_band);
               rsp_frame_end <= band_done && cur_ff.last_band;
               if (cell_last) begin
                  gx_ff <= '0;
                  ry_ff <= ry_ff + 1'b1;
                  if (band_done) cur_ff.last_band <= 1'b1;
               end else gx_ff <= gx_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // colour stored after the last division step; uses the final quotient
   always_ff @(posedge clock) begin
      if (reset) col_we_ff <= 1'b0;
      else col_we_ff <= (st_ff == S_DIV) && (div_cnt_ff == 5'd21)
                        && !(out_v_ff && !rsp_ready);
      col_px_ff <= px_ff;
      if (col_we_ff) col_ff[col_px_ff] <= ramp565(pidx);
   end

   assign rsp_valid = out_v_ff;
endmodule

>>> design/thermal_grid_upscale_colorize.sv
// channel | ports                  | direction
// req     | req_valid/ready/sample | in, one sensor sample per transfer
// rsp     | rsp_valid/ready/fields | out, one four-pixel cell per transfer
// csr     | csr_write/index/data   | in, register write, no wait
// a sample that ends a sensor row (not the first) produces 32 cells, the last row 64
// each pixel takes a multiply step, then 22 serial divide steps
// each pixel's final divide step and each cell's output can wait on rsp_ready
// reset is synchronous; a sample waits while the back end has a job queued or running
module thermal_grid_upscale_colorize (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_sample_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_pixel_row,
   output logic [2:0]  rsp_cell_column,
   output logic [15:0] rsp_colour_a,
   output logic [15:0] rsp_colour_b,
   output logic [15:0] rsp_colour_c,
   output logic [15:0] rsp_colour_d,
   output logic        rsp_run_last,
   output logic        rsp_frame_end,
   output logic signed [11:0] rsp_frame_peak,
   output logic [6:0]  rsp_peak_x,
   output logic [6:0]  rsp_peak_y,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   import tguc_pkg::*;
   logic signed [11:0] low_ff;
   logic [11:0] span_ff;
   logic job_valid, job_ready, back_busy, wr_en, frame_start;
   job_type job;
   logic [COL_W:0] wr_addr;
   logic signed [11:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= 12'sd80;
         span_ff <= 12'd80;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COLOR_LOW: low_ff <= csr_data;
            CSR_COLOR_SPAN: span_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tguc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_sample_code,
      .job_valid, .job, .job_ready, .back_busy, .wr_en, .wr_addr, .wr_data,
      .frame_start
   );

   tguc_back u_back (
      .clock, .reset, .job_valid, .job, .job_ready, .back_busy, .wr_en, .wr_addr,
      .wr_data, .frame_start, .color_low(low_ff), .color_span(span_ff),
      .rsp_valid, .rsp_ready, .rsp_pixel_row, .rsp_cell_column,
      .rsp_colour_a, .rsp_colour_b, .rsp_colour_c, .rsp_colour_d,
      .rsp_run_last, .rsp_frame_end, .rsp_frame_peak, .rsp_peak_x, .rsp_peak_y
   );
endmodule

>>> design/tguc_checker.sv
module tguc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_run_last,
   input logic rsp_frame_end,
   input logic [2:0] rsp_cell_column
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_last) else $error("frame end without run end");
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_cell_column == 3'd7) else $error("run end mid row");
endmodule

bind thermal_grid_upscale_colorize tguc_checker u_chk (.*);
